### rtl/hsv_pkg.sv
package hsv_pkg;

    localparam int HSV_CW = 8;
    localparam int HSV_PW = 2 * HSV_CW;
    localparam int HSV_YW = 3 * HSV_CW;
    localparam int HSV_RECIP_W = 25;
    localparam int HSV_RECIP_SHIFT = 40;
    localparam int HSV_SCALED_W = 11;

    localparam logic [HSV_CW-1:0] HSV_FULL = 8'd255;
    localparam logic [HSV_PW-1:0] HSV_FULL_SQ = 16'd65025;
    localparam logic [HSV_RECIP_W-1:0] HSV_RECIP = 25'd16909061;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } hsv_sector_t;

    typedef struct packed {
        hsv_sector_t       sector;
        logic [HSV_CW-1:0] frac;
        logic [HSV_CW-1:0] sat;
        logic [HSV_CW-1:0] val;
        logic [HSV_CW-1:0] alpha;
    } hsv_s1_t;

    typedef struct packed {
        hsv_sector_t       sector;
        logic [HSV_CW-1:0] val;
        logic [HSV_CW-1:0] alpha;
        logic [HSV_CW-1:0] p;
        logic [HSV_CW-1:0] q;
        logic [HSV_CW-1:0] t;
    } hsv_s4_t;

    function automatic logic [HSV_CW-1:0] hsv_div255(input logic [HSV_PW-1:0] x);
        logic [HSV_PW:0] sum;
        sum = {1'b0, x} + {{(HSV_CW+1){1'b0}}, x[HSV_PW-1:HSV_CW]} + 17'd1;
        return sum[HSV_PW-1:HSV_CW];
    endfunction

endpackage

### rtl/hsv_if.sv
interface hsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [7:0] alpha_in;

    modport source (output valid, output hue, output saturation, output brightness,
                    output alpha_in, input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  input alpha_in, output ready);
endinterface

interface hsv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;

    modport source (output valid, output red, output green, output blue,
                    output alpha_out, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input alpha_out, output ready);
endinterface

### rtl/hsv_sector.sv
module hsv_sector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [7:0]          hue,
    input  logic [7:0]          sat,
    input  logic [7:0]          val,
    input  logic [7:0]          alpha,
    output logic                out_valid,
    output hsv_pkg::hsv_s1_t    out_data
);
    import hsv_pkg::*;

    logic [HSV_SCALED_W-1:0] scaled;
    logic [HSV_SCALED_W-1:0] base;
    logic [2:0]              sec;
    logic                    valid_reg;
    hsv_s1_t                 data_reg;
    hsv_s1_t                 data_next;

    always_comb
    begin
        scaled = {{(HSV_SCALED_W-HSV_CW){1'b0}}, hue} * 11'd6;
        sec    = 3'd0;
        base   = '0;
        for (int k = 1; k <= 6; k++)
        begin
            if (scaled >= HSV_SCALED_W'(k * 255))
            begin
                sec  = 3'(k);
                base = HSV_SCALED_W'(k * 255);
            end
        end
        if (sec == 3'd6)
        begin
            sec = 3'(SEC_RY);
        end
        data_next.sector = hsv_sector_t'(sec);
        data_next.frac   = HSV_CW'(scaled - base);
        data_next.sat    = sat;
        data_next.val    = val;
        data_next.alpha  = alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.frac != HSV_FULL))
        else $error("fraction reached full scale");

endmodule

### rtl/hsv_scale.sv
module hsv_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  hsv_pkg::hsv_s1_t    in_data,
    output logic                out_valid,
    output hsv_pkg::hsv_s4_t    out_data
);
    import hsv_pkg::*;

    localparam int PROD_W = HSV_YW + HSV_RECIP_W;

    logic [2:0]          valid_reg;

    hsv_sector_t         sec2_reg;
    logic [HSV_CW-1:0]   val2_reg;
    logic [HSV_CW-1:0]   alpha2_reg;
    logic [HSV_PW-1:0]   mq2_reg;
    logic [HSV_PW-1:0]   mt2_reg;
    logic [HSV_PW-1:0]   pn2_reg;

    hsv_sector_t         sec3_reg;
    logic [HSV_CW-1:0]   val3_reg;
    logic [HSV_CW-1:0]   alpha3_reg;
    logic [HSV_CW-1:0]   p3_reg;
    logic [HSV_YW-1:0]   yq3_reg;
    logic [HSV_YW-1:0]   yt3_reg;

    hsv_s4_t             data4_reg;

    logic [HSV_CW-1:0]   cofrac;
    logic [HSV_CW-1:0]   cosat;
    logic [HSV_PW-1:0]   mq_next;
    logic [HSV_PW-1:0]   mt_next;
    logic [HSV_PW-1:0]   pn_next;
    logic [HSV_YW-1:0]   yq_next;
    logic [HSV_YW-1:0]   yt_next;
    logic [PROD_W-1:0]   prod_q;
    logic [PROD_W-1:0]   prod_t;

    always_comb
    begin
        cofrac  = HSV_FULL - in_data.frac;
        cosat   = HSV_FULL - in_data.sat;
        mq_next = {{HSV_CW{1'b0}}, in_data.sat} * {{HSV_CW{1'b0}}, in_data.frac};
        mt_next = {{HSV_CW{1'b0}}, in_data.sat} * {{HSV_CW{1'b0}}, cofrac};
        pn_next = {{HSV_CW{1'b0}}, in_data.val} * {{HSV_CW{1'b0}}, cosat};
        yq_next = {{HSV_PW{1'b0}}, val2_reg} * {{HSV_CW{1'b0}}, HSV_FULL_SQ - mq2_reg};
        yt_next = {{HSV_PW{1'b0}}, val2_reg} * {{HSV_CW{1'b0}}, HSV_FULL_SQ - mt2_reg};
        prod_q  = {{HSV_RECIP_W{1'b0}}, yq3_reg} * {{HSV_YW{1'b0}}, HSV_RECIP};
        prod_t  = {{HSV_RECIP_W{1'b0}}, yt3_reg} * {{HSV_YW{1'b0}}, HSV_RECIP};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec2_reg   <= in_data.sector;
            val2_reg   <= in_data.val;
            alpha2_reg <= in_data.alpha;
            mq2_reg    <= mq_next;
            mt2_reg    <= mt_next;
            pn2_reg    <= pn_next;

            sec3_reg   <= sec2_reg;
            val3_reg   <= val2_reg;
            alpha3_reg <= alpha2_reg;
            p3_reg     <= hsv_div255(pn2_reg);
            yq3_reg    <= yq_next;
            yt3_reg    <= yt_next;

            data4_reg.sector <= sec3_reg;
            data4_reg.val    <= val3_reg;
            data4_reg.alpha  <= alpha3_reg;
            data4_reg.p      <= p3_reg;
            data4_reg.q      <= prod_q[HSV_RECIP_SHIFT +: HSV_CW];
            data4_reg.t      <= prod_t[HSV_RECIP_SHIFT +: HSV_CW];
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = data4_reg;

    a_levels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (data4_reg.p <= data4_reg.val && data4_reg.q <= data4_reg.val
                          && data4_reg.t <= data4_reg.val))
        else $error("scaled level above brightness");

endmodule

### rtl/hsv_to_rgb_pixel_core.sv
// HSV to RGB pixel converter: accepts one pixel per clock on pix_in while pix_out is not
// stalled and delivers the matching red, green, blue and unchanged alpha on pix_out,
// in order. Hue 0..255 spans a full turn in six sectors; zero saturation
// gives grey at the brightness level. All five register stages share one advance
// signal, so backpressure on pix_out stalls the whole pipeline and pix_in.ready drops
// only while a result is waiting and pix_out.ready is low.
module hsv_to_rgb_pixel_core (
    input  logic       clk,
    input  logic       rst_n,
    hsv_in_if.sink     pix_in,
    hsv_out_if.source  pix_out
);
    import hsv_pkg::*;

    logic        adv;
    logic        s1_valid;
    hsv_s1_t     s1_data;
    logic        s4_valid;
    hsv_s4_t     s4_data;

    logic        out_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;

    assign adv          = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = adv;

    hsv_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pix_in.valid),
        .hue       (pix_in.hue),
        .sat       (pix_in.saturation),
        .val       (pix_in.brightness),
        .alpha     (pix_in.alpha_in),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    hsv_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s4_valid),
        .out_data  (s4_data)
    );

    always_comb
    begin
        case (s4_data.sector)
            SEC_RY:
            begin
                red_next = s4_data.val; green_next = s4_data.t;   blue_next = s4_data.p;
            end
            SEC_YG:
            begin
                red_next = s4_data.q;   green_next = s4_data.val; blue_next = s4_data.p;
            end
            SEC_GC:
            begin
                red_next = s4_data.p;   green_next = s4_data.val; blue_next = s4_data.t;
            end
            SEC_CB:
            begin
                red_next = s4_data.p;   green_next = s4_data.q;   blue_next = s4_data.val;
            end
            SEC_BM:
            begin
                red_next = s4_data.t;   green_next = s4_data.p;   blue_next = s4_data.val;
            end
            default:
            begin
                red_next = s4_data.val; green_next = s4_data.p;   blue_next = s4_data.q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= s4_data.alpha;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red       = red_reg;
    assign pix_out.green     = green_reg;
    assign pix_out.blue      = blue_reg;
    assign pix_out.alpha_out = alpha_reg;

    a_drain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid && adv) |=> out_valid_reg)
        else $error("finished pixel lost before output stage");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(s1_valid) && $stable(s4_valid) && $stable(s4_data)))
        else $error("pipeline moved during stall");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pix_out.ready) |=> (out_valid_reg
            && $stable({red_reg, green_reg, blue_reg, alpha_reg})))
        else $error("waiting result changed before acceptance");

endmodule

### bench/hsv_to_rgb_pixel_core_test.sv
`timescale 1ns / 100ps

module hsv_to_rgb_pixel_core_test;

    import hsv_pkg::*;

    localparam int RANDOM_PIXELS = 1200;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [HSV_CW-1:0] hue;
        logic [HSV_CW-1:0] sat;
        logic [HSV_CW-1:0] val;
        logic [HSV_CW-1:0] alpha;
    } hsv_pixel_t;

    typedef struct packed {
        logic [HSV_CW-1:0] red;
        logic [HSV_CW-1:0] green;
        logic [HSV_CW-1:0] blue;
        logic [HSV_CW-1:0] alpha;
    } rgba_pixel_t;

    logic clk;
    logic rst_n;

    hsv_in_if  pix_in ();
    hsv_out_if pix_out ();

    hsv_to_rgb_pixel_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out)
    );

    hsv_pixel_t  pixel_backlog[$];
    rgba_pixel_t rgba_due[$];
    int          drain_marks[$];
    hsv_pixel_t  pixel_on_bus;
    int          pixels_sent;
    int          pixels_seen;
    int          send_wait;
    int          recv_wait;
    bit          send_calm;
    bit          recv_calm;
    int          mismatch_count;
    int          idle_cycles;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rgba_pixel_t hsv_convert(hsv_pixel_t px);
        int unsigned  v;
        int unsigned  s;
        int unsigned  scaled;
        int unsigned  frac;
        int unsigned  p;
        int unsigned  q;
        int unsigned  t;
        hsv_sector_t  sector;
        rgba_pixel_t  res;
        v = px.val;
        s = px.sat;
        res.alpha = px.alpha;
        if (s == 0) begin
            res.red   = v[HSV_CW-1:0];
            res.green = v[HSV_CW-1:0];
            res.blue  = v[HSV_CW-1:0];
        end else begin
            scaled = int'(px.hue) * 6;
            frac   = scaled % int'(HSV_FULL);
            p = (v * (int'(HSV_FULL) - s)) / int'(HSV_FULL);
            q = (v * (int'(HSV_FULL_SQ) - s * frac)) / int'(HSV_FULL_SQ);
            t = (v * (int'(HSV_FULL_SQ) - s * (int'(HSV_FULL) - frac))) / int'(HSV_FULL_SQ);
            if (scaled / int'(HSV_FULL) >= 6)
                sector = SEC_RY;
            else
                sector = hsv_sector_t'(scaled / int'(HSV_FULL));
            case (sector)
                SEC_RY: {res.red, res.green, res.blue} = {v[7:0], t[7:0], p[7:0]};
                SEC_YG: {res.red, res.green, res.blue} = {q[7:0], v[7:0], p[7:0]};
                SEC_GC: {res.red, res.green, res.blue} = {p[7:0], v[7:0], t[7:0]};
                SEC_CB: {res.red, res.green, res.blue} = {p[7:0], q[7:0], v[7:0]};
                SEC_BM: {res.red, res.green, res.blue} = {t[7:0], p[7:0], v[7:0]};
                default: {res.red, res.green, res.blue} = {v[7:0], p[7:0], q[7:0]};
            endcase
        end
        return res;
    endfunction

    function automatic hsv_pixel_t random_pixel();
        hsv_pixel_t px;
        px.hue   = 8'($urandom_range(0, 255));
        px.sat   = 8'($urandom_range(0, 255));
        px.val   = 8'($urandom_range(0, 255));
        px.alpha = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: px.sat = 8'd0;
            1: px.hue = HSV_FULL;
            2: px.sat = HSV_FULL;
            3: px.val = $urandom_range(0, 1) ? HSV_FULL : 8'd0;
            4: px.hue = 8'($urandom_range(0, 5) * 85 / 2);
            default: ;
        endcase
        return px;
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // drive pixels
    always @(posedge clk or negedge rst_n)
    begin
        logic taken;
        logic load;
        if (!rst_n) begin
            pix_in.valid      <= 1'b0;
            pix_in.hue        <= '0;
            pix_in.saturation <= '0;
            pix_in.brightness <= '0;
            pix_in.alpha_in   <= '0;
            send_wait = 0;
        end else begin
            taken = pix_in.valid && pix_in.ready;
            load  = 1'b0;
            if (taken) begin
                rgba_due.push_back(hsv_convert(pixel_on_bus));
                pixels_sent++;
                if (pixels_sent % 50 == 0)
                    send_calm = ($urandom_range(0, 2) == 0);
            end
            if (!pix_in.valid || taken) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (drain_marks.size() != 0 && pixels_sent >= drain_marks[0]
                             && rgba_due.size() != 0) begin
                    // hold until the pipeline is empty
                end else if (pixel_backlog.size() != 0) begin
                    if (drain_marks.size() != 0 && pixels_sent >= drain_marks[0])
                        void'(drain_marks.pop_front());
                    load = 1'b1;
                    pixel_on_bus = pixel_backlog.pop_front();
                    pix_in.hue        <= pixel_on_bus.hue;
                    pix_in.saturation <= pixel_on_bus.sat;
                    pix_in.brightness <= pixel_on_bus.val;
                    pix_in.alpha_in   <= pixel_on_bus.alpha;
                    send_wait = draw_wait(send_calm);
                end
                pix_in.valid <= load;
            end
        end
    end

    // check results
    always @(posedge clk or negedge rst_n)
    begin
        rgba_pixel_t want;
        rgba_pixel_t got;
        if (!rst_n) begin
            pix_out.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                got = '{pix_out.red, pix_out.green, pix_out.blue, pix_out.alpha_out};
                if (rgba_due.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected transaction: r=%02x g=%02x b=%02x a=%02x",
                                 got.red, got.green, got.blue, got.alpha);
                    mismatch_count++;
                end else begin
                    want = rgba_due.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha) begin
                        if (mismatch_count < REPORT_MAX)
                            $display("result %0d: expected r=%02x g=%02x b=%02x a=%02x, %s",
                                     pixels_seen, want.red, want.green, want.blue,
                                     want.alpha,
                                     $sformatf("got r=%02x g=%02x b=%02x a=%02x",
                                               got.red, got.green, got.blue, got.alpha));
                        mismatch_count++;
                    end
                end
                pixels_seen++;
                if (pixels_seen % 50 == 0)
                    recv_calm = ($urandom_range(0, 2) == 0);
                recv_wait = draw_wait(recv_calm);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("hsv_to_rgb_pixel_core: mismatch");
        $finish;
    end

    initial begin
        hsv_pixel_t px;
        rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.hue = '0;
        pix_in.saturation = '0;
        pix_in.brightness = '0;
        pix_in.alpha_in = '0;
        pix_out.ready = 1'b0;
        idle_cycles = 0;
        pixels_sent = 0;
        pixels_seen = 0;
        mismatch_count = 0;
        send_calm = 1'b0;
        recv_calm = 1'b0;

        pixel_backlog.push_back('{8'd0,   8'd0,   8'd0,   8'd0});
        pixel_backlog.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
        pixel_backlog.push_back('{8'd255, 8'd200, 8'd180, 8'd17});
        pixel_backlog.push_back('{8'd0,   8'd255, 8'd255, 8'd0});
        pixel_backlog.push_back('{8'd90,  8'd0,   8'd123, 8'd200});
        pixel_backlog.push_back('{8'd200, 8'd0,   8'd255, 8'd1});
        pixel_backlog.push_back('{8'd17,  8'd1,   8'd255, 8'd128});
        pixel_backlog.push_back('{8'd42,  8'd255, 8'd255, 8'd64});
        pixel_backlog.push_back('{8'd43,  8'd255, 8'd255, 8'd65});
        pixel_backlog.push_back('{8'd85,  8'd255, 8'd255, 8'd66});
        pixel_backlog.push_back('{8'd86,  8'd255, 8'd255, 8'd67});
        pixel_backlog.push_back('{8'd127, 8'd255, 8'd255, 8'd68});
        pixel_backlog.push_back('{8'd128, 8'd255, 8'd255, 8'd69});
        pixel_backlog.push_back('{8'd170, 8'd255, 8'd255, 8'd70});
        pixel_backlog.push_back('{8'd171, 8'd255, 8'd255, 8'd71});
        pixel_backlog.push_back('{8'd212, 8'd255, 8'd255, 8'd72});
        pixel_backlog.push_back('{8'd213, 8'd255, 8'd255, 8'd73});
        pixel_backlog.push_back('{8'd254, 8'd255, 8'd255, 8'd74});
        pixel_backlog.push_back('{8'd254, 8'd128, 8'd200, 8'd170});
        pixel_backlog.push_back('{8'd100, 8'd255, 8'd0,   8'd85});
        pixel_backlog.push_back('{8'd60,  8'd1,   8'd1,   8'd255});
        pixel_backlog.push_back('{8'd150, 8'd170, 8'd85,  8'd0});
        pixel_backlog.push_back('{8'd240, 8'd85,  8'd170, 8'd255});
        drain_marks.push_back(pixel_backlog.size());
        drain_marks.push_back(pixel_backlog.size() + RANDOM_PIXELS / 2);
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            px = random_pixel();
            pixel_backlog.push_back(px);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_backlog.size() != 0 || pix_in.valid)
            @(posedge clk);
        while (rgba_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && rgba_due.size() == 0)
            $display("hsv_to_rgb_pixel_core: match");
        else
            $display("hsv_to_rgb_pixel_core: mismatch");
        $finish;
    end

endmodule
